// ===== hdl/gbr_pkg.sv =====
package gbr_pkg;

  localparam int MAX_ROW_LENGTH_DEF   = 1024;
  localparam int WEIGHT_FRAC_BITS_DEF = 16;
  localparam int MAX_ROWS             = 4096;
  localparam int ROW_W                = 12;   // row index 0..4095
  localparam int HEIGHT_W             = 13;   // row count 1..4096
  localparam int LEN_FIELD_W          = 11;
  localparam int CFG_DATA_W           = 13;
  localparam int CFG_INDEX_W          = 1;
  localparam int QUEUE_DEPTH          = 2;
  localparam int QCNT_W               = 2;
  localparam int MAX_INFLIGHT         = 3;
  localparam int TAP_W                = 3;
  localparam int TAP_LAST             = 4;
  localparam int TAP_HALF             = 2;
  localparam int BASE_FRAC            = 24;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROW_LENGTH = 1'b0,
    REG_ROW_COUNT  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_ACC,
    B_DIV,
    B_OUT
  } back_state_t;

  typedef struct packed {
    logic [QCNT_W-1:0] queued;
    logic              back_busy;
  } gbr_load_t;

  // round(2^24 * exp(-0.5*(a*a+b*b))) for tap offsets a, b in 0..2
  function automatic logic [BASE_FRAC:0] weight24(logic [1:0] a, logic [1:0] b);
    logic [3:0] d;
    logic [BASE_FRAC:0] w;
    d = 4'({2'b00, a} * {2'b00, a}) + 4'({2'b00, b} * {2'b00, b});
    case (d)
      4'd0:    w = 25'd16777216;
      4'd1:    w = 25'd10175896;
      4'd2:    w = 25'd6171993;
      4'd4:    w = 25'd2270549;
      4'd5:    w = 25'd1377158;
      4'd8:    w = 25'd307285;
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [BASE_FRAC:0] tap_weight(logic [1:0] a, logic [1:0] b,
                                                    int frac);
    logic [BASE_FRAC+1:0] s;
    int shift;
    shift = BASE_FRAC - frac;
    if (shift == 0) begin
      return weight24(a, b);
    end
    s = {1'b0, weight24(a, b)} + ((BASE_FRAC+2)'(1) << (shift - 1));
    return (BASE_FRAC+1)'(s >> shift);
  endfunction

endpackage

// ===== hdl/gbr_if.sv =====
interface gbr_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] pixel_in;

  modport source (output valid, command, pixel_in, input ready);
  modport sink   (input valid, command, pixel_in, output ready);
endinterface

interface gbr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic       frame_last;

  modport source (output valid, pixel_out, frame_last, input ready);
  modport sink   (input valid, pixel_out, frame_last, output ready);
endinterface

// ===== hdl/gbr_fifo.sv =====
module gbr_fifo #(
  parameter int DATA_W = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  logic [DATA_W-1:0]         wdata,
  input  logic                      pop,
  output logic [DATA_W-1:0]         rdata,
  output logic                      full,
  output logic                      empty,
  output logic [gbr_pkg::QCNT_W-1:0] count
);
  import gbr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [DATA_W-1:0] store_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rdata   = store_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wptr_r] <= wdata;
    end
  end

endmodule

// ===== hdl/gbr_front.sv =====
module gbr_front #(
  parameter int MAX_ROW_LENGTH = gbr_pkg::MAX_ROW_LENGTH_DEF,
  parameter int HIST           = 4 * MAX_ROW_LENGTH + 8,
  parameter int AW             = $clog2(HIST),
  parameter int COLW           = $clog2(MAX_ROW_LENGTH + 1),
  parameter int POS_W          = $clog2(MAX_ROW_LENGTH * gbr_pkg::MAX_ROWS + 1),
  parameter int JOB_W          = AW + gbr_pkg::ROW_W + COLW + 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gbr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gbr_pkg::CFG_DATA_W-1:0]  cfg_data,
  gbr_in_if.sink                          in_s,
  input  gbr_pkg::gbr_load_t              load,
  input  logic                            q_full,
  output logic                            wr_en,
  output logic [AW-1:0]                   wr_addr,
  output logic [7:0]                      wr_data,
  output logic                            push,
  output logic [JOB_W-1:0]                job,
  output logic [COLW-1:0]                 width,
  output logic [gbr_pkg::HEIGHT_W-1:0]    height
);
  import gbr_pkg::*;

  logic [LEN_FIELD_W-1:0] len_raw_r;
  logic [HEIGHT_W-1:0]    cnt_raw_r;
  logic [COLW-1:0]        w_eff;
  logic [HEIGHT_W-1:0]    h_eff;
  logic [POS_W-1:0]       p_total;

  logic [POS_W-1:0]  in_pos_r, in_pos_nxt, out_pos_r, out_pos_nxt;
  logic [AW-1:0]     wr_addr_r, wr_addr_nxt, out_addr_r, out_addr_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [COLW-1:0]   out_col_r, out_col_nxt;

  logic [QCNT_W:0]   inflight;
  logic              accept, is_pixel, frame_in, do_write, emit, last;
  logic [POS_W-1:0]  in_pos_inc;
  logic [POS_W:0]    thresh;

  always_comb begin
    if (len_raw_r == '0) begin
      w_eff = COLW'(1);
    end else if (32'(len_raw_r) > MAX_ROW_LENGTH) begin
      w_eff = COLW'(MAX_ROW_LENGTH);
    end else begin
      w_eff = COLW'(len_raw_r);
    end
    if (cnt_raw_r == '0) begin
      h_eff = HEIGHT_W'(1);
    end else if (32'(cnt_raw_r) > MAX_ROWS) begin
      h_eff = HEIGHT_W'(MAX_ROWS);
    end else begin
      h_eff = cnt_raw_r;
    end
  end

  assign p_total = POS_W'(w_eff) * POS_W'(h_eff);
  assign width   = w_eff;
  assign height  = h_eff;

  // Hold back while too many results are pending, and keep a new frame from
  // overwriting history that jobs of the previous frame still read.
  assign inflight   = {1'b0, load.queued} + (QCNT_W+1)'(load.back_busy);
  assign in_s.ready = !q_full && (inflight < (QCNT_W+1)'(MAX_INFLIGHT)) &&
                      !((in_pos_r == '0) && (inflight != '0));

  assign accept     = in_s.valid && in_s.ready;
  assign is_pixel   = (in_s.command == CMD_PIXEL);
  assign frame_in   = (in_pos_r >= p_total);
  assign do_write   = accept && is_pixel && !frame_in;
  assign in_pos_inc = in_pos_r + 1'b1;
  assign thresh     = {1'b0, out_pos_r} + (POS_W+1)'({w_eff, 1'b0}) + (POS_W+1)'(3);
  assign last       = (out_pos_r == p_total - 1'b1);

  always_comb begin
    if (do_write) begin
      emit = ({1'b0, in_pos_inc} >= thresh);
    end else begin
      emit = accept && !is_pixel && frame_in && (out_pos_r < p_total);
    end
  end

  always_comb begin
    in_pos_nxt   = in_pos_r;
    wr_addr_nxt  = wr_addr_r;
    out_pos_nxt  = out_pos_r;
    out_addr_nxt = out_addr_r;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    if (do_write) begin
      in_pos_nxt  = in_pos_inc;
      wr_addr_nxt = (wr_addr_r == AW'(HIST-1)) ? '0 : wr_addr_r + 1'b1;
    end
    if (emit) begin
      out_pos_nxt  = out_pos_r + 1'b1;
      out_addr_nxt = (out_addr_r == AW'(HIST-1)) ? '0 : out_addr_r + 1'b1;
      if (out_col_r == w_eff - 1'b1) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + 1'b1;
      end else begin
        out_col_nxt = out_col_r + 1'b1;
      end
      if (last) begin
        in_pos_nxt   = '0;
        wr_addr_nxt  = '0;
        out_pos_nxt  = '0;
        out_addr_nxt = '0;
        out_row_nxt  = '0;
        out_col_nxt  = '0;
      end
    end
    if (cfg_we) begin
      in_pos_nxt   = '0;
      wr_addr_nxt  = '0;
      out_pos_nxt  = '0;
      out_addr_nxt = '0;
      out_row_nxt  = '0;
      out_col_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_raw_r  <= LEN_FIELD_W'(256);
      cnt_raw_r  <= HEIGHT_W'(256);
      in_pos_r   <= '0;
      wr_addr_r  <= '0;
      out_pos_r  <= '0;
      out_addr_r <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_ROW_LENGTH: len_raw_r <= cfg_data[LEN_FIELD_W-1:0];
          REG_ROW_COUNT:  cnt_raw_r <= cfg_data[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      in_pos_r   <= in_pos_nxt;
      wr_addr_r  <= wr_addr_nxt;
      out_pos_r  <= out_pos_nxt;
      out_addr_r <= out_addr_nxt;
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
    end
  end

  assign wr_en   = do_write;
  assign wr_addr = wr_addr_r;
  assign wr_data = in_s.pixel_in;
  assign push    = emit;
  assign job     = {out_addr_r, out_row_r, out_col_r, last};

endmodule

// ===== hdl/gbr_back.sv =====
module gbr_back #(
  parameter int MAX_ROW_LENGTH   = gbr_pkg::MAX_ROW_LENGTH_DEF,
  parameter int WEIGHT_FRAC_BITS = gbr_pkg::WEIGHT_FRAC_BITS_DEF,
  parameter int HIST             = 4 * MAX_ROW_LENGTH + 8,
  parameter int AW               = $clog2(HIST),
  parameter int COLW             = $clog2(MAX_ROW_LENGTH + 1),
  parameter int JOB_W            = AW + gbr_pkg::ROW_W + COLW + 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [7:0]                   wr_data,
  input  logic [JOB_W-1:0]             job,
  input  logic                         q_empty,
  output logic                         pop,
  output logic                         busy,
  input  logic [COLW-1:0]              width,
  input  logic [gbr_pkg::HEIGHT_W-1:0] height,
  gbr_out_if.source                    out_s
);
  import gbr_pkg::*;

  localparam int WT_W  = WEIGHT_FRAC_BITS + 1;
  localparam int WS_W  = WEIGHT_FRAC_BITS + 5;   // 25 taps
  localparam int ACC_W = WEIGHT_FRAC_BITS + 13;

  function automatic logic [AW-1:0] add_mod(logic [AW-1:0] a, logic [AW:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + b;
    if (s >= (AW+1)'(HIST)) begin
      s = s - (AW+1)'(HIST);
    end
    return s[AW-1:0];
  endfunction

  logic [7:0] mem [HIST];
  logic [7:0] rdata_r;

  back_state_t state_r, state_nxt;

  logic [AW-1:0]    center;
  logic [ROW_W-1:0] job_row;
  logic [COLW-1:0]  job_col;
  logic             job_last;

  logic [ROW_W-1:0] row_r;
  logic [COLW-1:0]  col_r;
  logic             last_r;
  logic [AW-1:0]    addr_r, row_start_r;
  logic [TAP_W-1:0] ti_r, tj_r;
  logic [ACC_W-1:0] acc_r;
  logic [WS_W-1:0]  wsum_r;
  logic [2:0]       bit_r;
  logic [7:0]       q_r;

  logic [ROW_W:0]   rp;
  logic [COLW:0]    cp;
  logic             tap_ok, tap_end, row_end;
  logic [1:0]       da, db;
  logic [WT_W-1:0]  wt;
  logic [ACC_W-1:0] divisor;
  logic             ge;

  assign {center, job_row, job_col, job_last} = job;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[addr_r];
  end

  // tap validity: row + ti - 2 in [0, height), col + tj - 2 in [0, width)
  assign rp     = {1'b0, row_r} + (ROW_W+1)'(ti_r);
  assign cp     = {1'b0, col_r} + (COLW+1)'(tj_r);
  assign tap_ok = (rp >= (ROW_W+1)'(TAP_HALF)) &&
                  (32'(rp) < 32'(height) + TAP_HALF) &&
                  (cp >= (COLW+1)'(TAP_HALF)) &&
                  (32'(cp) < 32'(width) + TAP_HALF);
  assign da     = (ti_r >= TAP_W'(TAP_HALF)) ? 2'(ti_r - TAP_W'(TAP_HALF))
                                             : 2'(TAP_W'(TAP_HALF) - ti_r);
  assign db     = (tj_r >= TAP_W'(TAP_HALF)) ? 2'(tj_r - TAP_W'(TAP_HALF))
                                             : 2'(TAP_W'(TAP_HALF) - tj_r);
  assign wt     = WT_W'(tap_weight(da, db, WEIGHT_FRAC_BITS));
  assign row_end = (tj_r == TAP_W'(TAP_LAST));
  assign tap_end = row_end && (ti_r == TAP_W'(TAP_LAST));

  assign divisor = ACC_W'(wsum_r) << bit_r;
  assign ge      = (acc_r >= divisor);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: if (!q_empty) state_nxt = B_READ;
      B_READ: state_nxt = B_ACC;
      B_ACC:  state_nxt = tap_end ? B_DIV : B_READ;
      B_DIV:  if (bit_r == '0) state_nxt = B_OUT;
      B_OUT:  if (out_s.ready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop         = 1'b0;
    busy        = 1'b1;
    out_s.valid = 1'b0;
    case (state_r)
      B_IDLE: begin
        pop  = !q_empty;
        busy = 1'b0;
      end
      B_OUT:  out_s.valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        row_r       <= job_row;
        col_r       <= job_col;
        last_r      <= job_last;
        ti_r        <= '0;
        tj_r        <= '0;
        acc_r       <= '0;
        wsum_r      <= '0;
        // top-left tap sits 2 rows and 2 pixels back in the history
        addr_r      <= add_mod(center, (AW+1)'(HIST-2) - (AW+1)'({width, 1'b0}));
        row_start_r <= add_mod(center, (AW+1)'(HIST-2) - (AW+1)'({width, 1'b0}));
      end
      B_ACC: begin
        if (tap_ok) begin
          acc_r  <= acc_r + ACC_W'(rdata_r) * ACC_W'(wt);
          wsum_r <= wsum_r + WS_W'(wt);
        end
        if (row_end) begin
          tj_r        <= '0;
          ti_r        <= ti_r + 1'b1;
          addr_r      <= add_mod(row_start_r, (AW+1)'(width));
          row_start_r <= add_mod(row_start_r, (AW+1)'(width));
        end else begin
          tj_r   <= tj_r + 1'b1;
          addr_r <= add_mod(addr_r, (AW+1)'(1));
        end
        bit_r <= 3'd7;
      end
      B_DIV: begin
        if (ge) begin
          acc_r <= acc_r - divisor;
        end
        q_r   <= {q_r[6:0], ge};
        bit_r <= bit_r - 1'b1;
      end
      default: ;
    endcase
  end

  assign out_s.pixel_out  = q_r;
  assign out_s.frame_last = last_r;

endmodule

// ===== hdl/gaussian_blur_5x5_edge_renorm.sv =====
// 5x5 Gaussian blur (sigma 1) over a raster stream of 8-bit gray pixels, with
// weights renormalized to the taps inside the frame. The output for raster
// index k-(2*row_length+2) leaves once index k has arrived; drain commands
// flush the tail after the last pixel. Each result is built by a single
// shared unit that walks the 25 taps through the one read port of the history
// memory, then runs an 8-step restoring divide; it finishes one result before
// it takes the next. The front keeps taking input while the two-entry job
// queue has room and fewer than three results are queued or in work, and the
// first pixel of a new frame waits until every result of the previous frame
// has left. The history memory holds 4*MAX_ROW_LENGTH+8 pixels and needs no
// clearing after reset. A configuration write restarts the frame and must
// happen only while the block is idle.
module gaussian_blur_5x5_edge_renorm #(
  parameter int MAX_ROW_LENGTH   = gbr_pkg::MAX_ROW_LENGTH_DEF,
  parameter int WEIGHT_FRAC_BITS = gbr_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gbr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gbr_pkg::CFG_DATA_W-1:0]  cfg_data,
  gbr_in_if.sink                          in_s,
  gbr_out_if.source                       out_s
);
  import gbr_pkg::*;

  localparam int HIST  = 4 * MAX_ROW_LENGTH + 8;
  localparam int AW    = $clog2(HIST);
  localparam int COLW  = $clog2(MAX_ROW_LENGTH + 1);
  localparam int POS_W = $clog2(MAX_ROW_LENGTH * MAX_ROWS + 1);
  localparam int JOB_W = AW + ROW_W + COLW + 1;

  gbr_load_t          load;
  logic               wr_en, push, pop, q_full, q_empty, back_busy;
  logic [AW-1:0]      wr_addr;
  logic [7:0]         wr_data;
  logic [JOB_W-1:0]   job_in, job_out;
  logic [COLW-1:0]    width;
  logic [HEIGHT_W-1:0] height;
  logic [QCNT_W-1:0]  q_count;

  assign load.queued    = q_count;
  assign load.back_busy = back_busy;

  gbr_front #(
    .MAX_ROW_LENGTH(MAX_ROW_LENGTH),
    .HIST(HIST), .AW(AW), .COLW(COLW), .POS_W(POS_W), .JOB_W(JOB_W)
  ) u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_s,
    .load, .q_full,
    .wr_en, .wr_addr, .wr_data,
    .push, .job(job_in),
    .width, .height
  );

  gbr_fifo #(
    .DATA_W(JOB_W)
  ) u_fifo (
    .clk, .rst_n,
    .push, .wdata(job_in),
    .pop, .rdata(job_out),
    .full(q_full), .empty(q_empty), .count(q_count)
  );

  gbr_back #(
    .MAX_ROW_LENGTH(MAX_ROW_LENGTH), .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS),
    .HIST(HIST), .AW(AW), .COLW(COLW), .JOB_W(JOB_W)
  ) u_back (
    .clk, .rst_n,
    .wr_en, .wr_addr, .wr_data,
    .job(job_out), .q_empty, .pop, .busy(back_busy),
    .width, .height,
    .out_s
  );

endmodule
